/* hw/rtl/smed_pkg.sv */
`default_nettype none
package smed_pkg;

  // store geometry and field widths
  localparam int DEPTH        = 256;
  localparam int SAMPLE_WIDTH = 16;
  localparam int COUNT_WIDTH  = $clog2(DEPTH + 1);
  localparam int REM_WIDTH    = COUNT_WIDTH - 1;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [COUNT_WIDTH-1:0]         count_t;
  typedef logic [REM_WIDTH-1:0]           rem_t;

  // sequencer states
  typedef enum logic {
    ST_FILL,
    ST_SHIFT
  } state_t;

  // control word from sequencer to the cell row
  typedef struct packed {
    logic    insert;
    logic    shift;
    sample_t sample;
  } chain_ctl_t;

endpackage
`default_nettype wire

/* hw/rtl/smed_in_if.sv */
`default_nettype none
interface smed_in_if;
  import smed_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;
  logic    sample_valid;
  logic    last;

  modport source (output valid, output sample, output sample_valid, output last,
                  input ready);
  modport sink   (input valid, input sample, input sample_valid, input last,
                  output ready);
endinterface
`default_nettype wire

/* hw/rtl/smed_out_if.sv */
`default_nettype none
interface smed_out_if;
  import smed_pkg::*;

  logic    valid;
  logic    ready;
  sample_t median;
  count_t  set_count;
  logic    overflow;

  modport source (output valid, output median, output set_count, output overflow,
                  input ready);
  modport sink   (input valid, input median, input set_count, input overflow,
                  output ready);
endinterface
`default_nettype wire

/* hw/rtl/smed_cell.sv */
`default_nettype none
module smed_cell (
  input  wire logic                clk,
  input  wire smed_pkg::chain_ctl_t ctl,
  input  wire logic                occ,
  input  wire logic                left_gt,
  input  wire smed_pkg::sample_t   left_value,
  input  wire smed_pkg::sample_t   right_value,
  output smed_pkg::sample_t        value,
  output logic                     gt
);
  import smed_pkg::*;

  sample_t value_next;

  // held entry is larger than the incoming sample
  assign gt = occ && (value > ctl.sample);

  // insert: larger entries move right, the first larger-or-empty slot takes the sample
  always_comb begin
    value_next = value;
    if (ctl.shift) begin
      value_next = right_value;
    end else if (ctl.insert) begin
      if (left_gt) begin
        value_next = left_value;
      end else if (gt || !occ) begin
        value_next = ctl.sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule
`default_nettype wire

/* hw/rtl/smed_chain.sv */
`default_nettype none
module smed_chain (
  input  wire logic                 clk,
  input  wire smed_pkg::chain_ctl_t ctl,
  input  wire smed_pkg::count_t     held_count,
  output smed_pkg::sample_t         head0,
  output smed_pkg::sample_t         head1
);
  import smed_pkg::*;

  sample_t          value [DEPTH];
  logic [DEPTH-1:0] gt;
  logic [DEPTH-1:0] occ;

  // row of sorting cells, entry 0 holds the smallest sample
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sample_t lv;
    sample_t rv;
    logic    lg;

    assign occ[i] = COUNT_WIDTH'(i) < held_count;

    if (i == 0) begin : g_first
      assign lv = '0;
      assign lg = 1'b0;
    end else begin : g_mid
      assign lv = value[i-1];
      assign lg = gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign rv = '0;
    end else begin : g_inner
      assign rv = value[i+1];
    end

    smed_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occ         (occ[i]),
      .left_gt     (lg),
      .left_value  (lv),
      .right_value (rv),
      .value       (value[i]),
      .gt          (gt[i])
    );
  end

  assign head0 = value[0];
  assign head1 = value[1];

endmodule
`default_nettype wire

/* hw/rtl/smed_ctrl.sv */
`default_nettype none
module smed_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  smed_in_if.sink                samples,
  smed_out_if.source             result,
  input  wire smed_pkg::sample_t head0,
  input  wire smed_pkg::sample_t head1,
  output smed_pkg::chain_ctl_t   ctl,
  output smed_pkg::count_t       held_count
);
  import smed_pkg::*;

  state_t state, state_next;
  logic   dropped;
  rem_t   remain;

  logic   accept, full, ins, drop_next, out_free, load;
  count_t count_next;
  count_t close_dec;
  logic signed [SAMPLE_WIDTH:0] pair_sum;
  logic signed [SAMPLE_WIDTH:0] pair_adj;
  sample_t median_next;

  assign accept     = samples.valid && samples.ready;
  assign full       = held_count == COUNT_WIDTH'(DEPTH);
  assign ins        = accept && samples.sample_valid && !full;
  assign drop_next  = dropped || (samples.sample_valid && full);
  assign count_next = held_count + COUNT_WIDTH'(samples.sample_valid && !full);
  assign close_dec  = (count_next == '0) ? '0 : count_next - 1'b1;
  assign out_free   = !result.valid || result.ready;
  assign load       = (state == ST_SHIFT) && (remain == '0) && out_free;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_FILL:  if (accept && samples.last) state_next = ST_SHIFT;
      ST_SHIFT: if (load) state_next = ST_FILL;
      default:  state_next = ST_FILL;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    samples.ready = 1'b0;
    ctl.shift     = 1'b0;
    case (state)
      ST_FILL:  samples.ready = 1'b1;
      ST_SHIFT: ctl.shift = remain != '0;
      default:  samples.ready = 1'b0;
    endcase
    ctl.insert = ins;
    ctl.sample = samples.sample;
  end

  // middle pair after the shifts sits at the head; halve toward zero
  always_comb begin
    pair_sum = {head0[SAMPLE_WIDTH-1], head0} + {head1[SAMPLE_WIDTH-1], head1};
    pair_adj = pair_sum + {{SAMPLE_WIDTH{1'b0}}, pair_sum[SAMPLE_WIDTH]};
    if (held_count == '0) begin
      median_next = '0;
    end else if (!held_count[0]) begin
      median_next = pair_adj[SAMPLE_WIDTH:1];
    end else begin
      median_next = head0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_FILL;
      held_count <= '0;
      dropped    <= 1'b0;
      remain     <= '0;
      result.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        held_count <= count_next;
        dropped    <= drop_next;
        remain     <= close_dec[COUNT_WIDTH-1:1];
      end else if (state == ST_SHIFT && remain != '0) begin
        remain <= remain - 1'b1;
      end
      if (load) begin
        held_count   <= '0;
        dropped      <= 1'b0;
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (load) begin
      result.median    <= median_next;
      result.set_count <= held_count;
      result.overflow  <= dropped;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/sample_set_median_unit.sv */
`default_nettype none
// Median of a set of signed samples.
// samples: input words {sample, sample_valid, last}, valid/ready handshake.
//   A word with sample_valid adds its sample; a word with last closes the set
//   (a sample on the same word is included) and yields one result word.
// result: output words {median, set_count, overflow}, valid/ready handshake.
// Throughput: one sample word per cycle outside a close; samples are
//   insertion-sorted by a row of DEPTH cells that compare against the new
//   sample in parallel. A close shifts the row left (n-1)/2 times to bring
//   the middle pair to its head (n = samples held), then registers the
//   result when the output is free; samples.ready is low meanwhile.
// Even counts give the middle pair's sum halved toward zero; an empty set
//   gives 0. Samples beyond DEPTH are dropped and flagged with overflow.
// A held result does not block new samples; a later close waits in the
//   shift phase until the output register is free.
// Reset (rst, synchronous) empties the set and clears the result valid.
module sample_set_median_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  smed_in_if.sink    samples,
  smed_out_if.source result
);
  import smed_pkg::*;

  chain_ctl_t ctl;
  count_t     held_count;
  sample_t    head0, head1;

  smed_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples),
    .result     (result),
    .head0      (head0),
    .head1      (head1),
    .ctl        (ctl),
    .held_count (held_count)
  );

  smed_chain u_chain (
    .clk        (clk),
    .ctl        (ctl),
    .held_count (held_count),
    .head0      (head0),
    .head1      (head1)
  );

endmodule
`default_nettype wire

/* test/tb_sample_set_median_unit.sv */
`default_nettype none
module tb_sample_set_median_unit;
  import smed_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RAND_ITEMS   = 640;
  localparam int MAX_REPORTS  = 10;
  localparam int N_DIRECTED   = 23;
  // phases of the random part that get special treatment
  localparam int FULL_PHASE   = 0;
  localparam int PAUSE_PHASE  = 1;
  localparam int OVER_PHASE   = 2;

  typedef struct packed {
    sample_t median;
    count_t  set_count;
    logic    overflow;
  } med_res_t;

  typedef struct packed {
    sample_t smp;
    logic    smp_valid;
    logic    close;
    logic    typed;
    sample_t e_median;
    count_t  e_count;
    logic    e_ovf;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycle_count = 0;
  int   fail_count  = 0;
  bit   calm        = 1'b0;

  smed_in_if  in_ch ();
  smed_out_if out_ch ();

  sample_set_median_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (in_ch),
    .result  (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // sorted copy of the set, as the block should hold it
  sample_t  sorted_set [DEPTH];
  int       held_n  = 0;
  bit       dropped = 1'b0;
  med_res_t pending_medians [$];
  dir_row_t dir_rows [N_DIRECTED];

  // fold one accepted word into the sorted set; report the median on close
  task automatic fold_word(input sample_t s, input logic sv, input logic lst,
                           output logic closed, output med_res_t res);
    int pos;
    int sum;
    closed = 1'b0;
    res    = '0;
    if (sv) begin
      if (held_n >= DEPTH) begin
        dropped = 1'b1;
      end else begin
        pos = held_n;
        while (pos > 0 && sorted_set[pos-1] > s) begin
          sorted_set[pos] = sorted_set[pos-1];
          pos--;
        end
        sorted_set[pos] = s;
        held_n++;
      end
    end
    if (lst) begin
      closed = 1'b1;
      if (held_n == 0) begin
        res.median = '0;
      end else if ((held_n % 2) == 0) begin
        // exact sum, halved toward zero
        sum = int'(sorted_set[(held_n-1)/2]) + int'(sorted_set[(held_n+1)/2]);
        res.median = sample_t'(sum / 2);
      end else begin
        res.median = sorted_set[held_n/2];
      end
      res.set_count = count_t'(held_n);
      res.overflow  = dropped;
      held_n  = 0;
      dropped = 1'b0;
    end
  endtask

  // present one word after a random gap, wait for the handshake, predict
  task automatic drive_word(input sample_t s, input logic sv, input logic lst,
                            input logic typed, input med_res_t typed_res);
    int       gap;
    logic     closed;
    med_res_t res;
    gap = calm ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid  <= 1'b0;
      in_ch.sample <= sample_t'($urandom);
    end
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.sample       <= s;
    in_ch.sample_valid <= sv;
    in_ch.last         <= lst;
    do @(posedge clk); while (!in_ch.ready);
    fold_word(s, sv, lst, closed, res);
    if (closed) pending_medians.push_back(typed ? typed_res : res);
  endtask

  function automatic sample_t pick_sample();
    sample_t v;
    case ($urandom_range(0, 5))
      0, 1:    v = sample_t'($urandom);
      2:       v = sample_t'(int'($urandom_range(0, 8)) - 4);
      3:       v = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      4:       v = $urandom_range(0, 1) ? 16'sh7FFF - sample_t'($urandom_range(0, 3))
                                        : 16'sh8000 + sample_t'($urandom_range(0, 3));
      default: v = sample_t'($urandom & 32'h0000_00FF);
    endcase
    return v;
  endfunction

  // one set of n samples, closed either on the last sample or by a bare close
  task automatic send_set(input int n, input bit noisy, inout int counted);
    if (n == 0) begin
      drive_word(sample_t'($urandom), 1'b0, 1'b1, 1'b0, '0);
      counted++;
    end else begin
      for (int k = 0; k < n; k++) begin
        if (noisy && $urandom_range(0, 5) == 0)
          drive_word(sample_t'($urandom), 1'b0, 1'b0, 1'b0, '0);
        if (k < n - 1) begin
          drive_word(pick_sample(), 1'b1, 1'b0, 1'b0, '0);
        end else if ($urandom_range(0, 1)) begin
          drive_word(pick_sample(), 1'b1, 1'b1, 1'b0, '0);
        end else begin
          drive_word(pick_sample(), 1'b1, 1'b0, 1'b0, '0);
          drive_word(sample_t'($urandom), 1'b0, 1'b1, 1'b0, '0);
          counted++;
        end
        counted++;
      end
    end
  endtask

  // result side: random stalls, compare against the oldest expectation
  initial begin
    int       stall;
    med_res_t want;
    wait (!rst);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      if (pending_medians.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result word: median %0d count %0d overflow %0b",
                   out_ch.median, out_ch.set_count, out_ch.overflow);
      end else begin
        want = pending_medians.pop_front();
        if (out_ch.median !== want.median || out_ch.set_count !== want.set_count ||
            out_ch.overflow !== want.overflow) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("result mismatch: median %0d/%0d count %0d/%0d overflow %0b/%0b (exp/got)",
                     want.median, out_ch.median, want.set_count, out_ch.set_count,
                     want.overflow, out_ch.overflow);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int       counted;
    int       phase;
    int       n;
    med_res_t typed_res;

    // smp, smp_valid, close, typed, e_median, e_count, e_ovf
    dir_rows = '{
      '{16'sh0000, 1'b0, 1'b1, 1'b1, 16'sh0000, 9'd0, 1'b0},  // empty after reset
      '{16'sh5A5A, 1'b0, 1'b0, 1'b0, 16'sh0000, 9'd0, 1'b0},  // ignored word
      '{16'sh8000, 1'b1, 1'b1, 1'b1, 16'sh8000, 9'd1, 1'b0},
      '{16'sh7FFF, 1'b1, 1'b1, 1'b1, 16'sh7FFF, 9'd1, 1'b0},
      '{16'sh8000, 1'b1, 1'b0, 1'b0, 16'sh0000, 9'd0, 1'b0},  // min + max: -1/2 -> 0
      '{16'sh7FFF, 1'b1, 1'b1, 1'b1, 16'sh0000, 9'd2, 1'b0},
      '{16'sh7FFF, 1'b1, 1'b0, 1'b0, 16'sh0000, 9'd0, 1'b0},
      '{16'sh7FFF, 1'b1, 1'b1, 1'b1, 16'sh7FFF, 9'd2, 1'b0},
      '{16'sh8000, 1'b1, 1'b0, 1'b0, 16'sh0000, 9'd0, 1'b0},
      '{16'sh8000, 1'b1, 1'b1, 1'b1, 16'sh8000, 9'd2, 1'b0},
      '{16'shFFFD, 1'b1, 1'b0, 1'b0, 16'sh0000, 9'd0, 1'b0},  // -3, 0: truncates to -1
      '{16'sh0000, 1'b1, 1'b1, 1'b1, 16'shFFFF, 9'd2, 1'b0},
      '{16'sh0005, 1'b1, 1'b0, 1'b0, 16'sh0000, 9'd0, 1'b0},
      '{16'sh0001, 1'b1, 1'b0, 1'b0, 16'sh0000, 9'd0, 1'b0},
      '{16'sh0003, 1'b1, 1'b0, 1'b0, 16'sh0000, 9'd0, 1'b0},
      '{16'sh0000, 1'b0, 1'b1, 1'b0, 16'sh0000, 9'd0, 1'b0},  // bare close, odd count
      '{16'sh0009, 1'b1, 1'b0, 1'b0, 16'sh0000, 9'd0, 1'b0},  // descending + duplicate
      '{16'sh0007, 1'b1, 1'b0, 1'b0, 16'sh0000, 9'd0, 1'b0},
      '{16'sh0007, 1'b1, 1'b0, 1'b0, 16'sh0000, 9'd0, 1'b0},
      '{16'shFFFE, 1'b1, 1'b0, 1'b0, 16'sh0000, 9'd0, 1'b0},
      '{16'sh0004, 1'b1, 1'b1, 1'b0, 16'sh0000, 9'd0, 1'b0},
      '{16'sh0000, 1'b0, 1'b1, 1'b1, 16'sh0000, 9'd0, 1'b0},  // empty again
      '{16'sh04D2, 1'b0, 1'b1, 1'b1, 16'sh0000, 9'd0, 1'b0}   // close ignores its sample
    };

    in_ch.valid        = 1'b0;
    in_ch.sample       = '0;
    in_ch.sample_valid = 1'b0;
    in_ch.last         = 1'b0;
    out_ch.ready       = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < N_DIRECTED; i++) begin
      typed_res = '{median: dir_rows[i].e_median, set_count: dir_rows[i].e_count,
                    overflow: dir_rows[i].e_ovf};
      drive_word(dir_rows[i].smp, dir_rows[i].smp_valid, dir_rows[i].close,
                 dir_rows[i].typed, typed_res);
    end

    // random sets in phases; two phases also carry a full and an overfull set
    counted = 0;
    phase   = 0;
    while (counted < RAND_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      if (phase == PAUSE_PHASE) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_medians.size() > 0) @(negedge clk);
      end
      if (phase == FULL_PHASE) begin
        n = DEPTH;
        send_set(n, 1'b0, counted);
      end
      if (phase == OVER_PHASE) begin
        n = DEPTH + $urandom_range(1, 5);
        send_set(n, 1'b1, counted);
      end
      for (int s = 0; s < 12; s++) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(0, 10);
        send_set(n, 1'b1, counted);
        // stray words between sets
        if ($urandom_range(0, 4) == 0)
          drive_word(sample_t'($urandom), 1'b0, 1'b0, 1'b0, '0);
      end
      phase++;
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_medians.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
hw/rtl/smed_pkg.sv
hw/rtl/smed_in_if.sv
hw/rtl/smed_out_if.sv
hw/rtl/smed_cell.sv
hw/rtl/smed_chain.sv
hw/rtl/smed_ctrl.sv
hw/rtl/sample_set_median_unit.sv
test/tb_sample_set_median_unit.sv
